// ===== rtl/sgm_pkg.sv =====
`default_nettype none
package sgm_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PIXEL_BITS = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = 12;
  localparam int CFG_BITS   = 12;
  localparam int GRAD_BITS  = 11;
  localparam int MAG_BITS   = 11;
  localparam int ANG_BITS   = 13;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  // Register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

  // Angles in 1/4096 degree
  localparam logic signed [21:0] ANG_90  = 22'sd368640;
  localparam logic        [21:0] ANG_180 = 22'd737280;
  localparam logic        [21:0] ANG_360 = 22'd1474560;
  localparam logic        [13:0] ANG_FULL_OUT = 14'd5760;

  // atan(2^-i) in 1/4096 degree
  localparam logic [17:0] ATAN_TAB [16] = '{
    18'd184320, 18'd108810, 18'd57492, 18'd29184, 18'd14649, 18'd7331,
    18'd3667, 18'd1833, 18'd917, 18'd458, 18'd229, 18'd115, 18'd57,
    18'd29, 18'd14, 18'd7
  };

  // One gradient item between front and back
  typedef struct packed {
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
    logic                        last;
  } grad_t;

endpackage
`default_nettype wire

// ===== rtl/sgm_ram.sv =====
`default_nettype none
module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sgm_front.sv =====
`default_nettype none
module sgm_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_addr,
  input  wire logic [sgm_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  wire logic                             in_push,
  input  wire logic [sgm_pkg::PIXEL_BITS-1:0]   in_pixel,
  output      logic                             in_full,
  input  wire logic                             q_full,
  output      logic                             q_push,
  output      sgm_pkg::grad_t                   q_data
);

  localparam int PB = sgm_pkg::PIXEL_BITS;
  localparam int CB = sgm_pkg::COL_BITS;
  localparam int RB = sgm_pkg::ROW_BITS;
  localparam int FB = sgm_pkg::CFG_BITS;

  logic [FB-1:0] width_r, height_r;
  logic [CB-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [FB-1:0] w_eff, h_eff;
  logic          row_end, frame_end, accept;

  // stage after the line store read
  logic          s1_v_r, s1_int_r, s1_last_r, s1_done;
  logic [PB-1:0] s1_pix_r;
  logic [CB-1:0] s1_col_r;
  logic [PB-1:0] win_r [6];
  logic [2*PB-1:0] rd_data;
  logic [PB-1:0] up, mid;
  logic signed [PB+3:0] gx, gy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sgm_pkg::WIDTH_RESET;
      height_r <= sgm_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        sgm_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        sgm_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    w_eff = width_r;
    if (width_r < FB'(3)) w_eff = FB'(3);
    if (width_r > FB'(sgm_pkg::MAX_WIDTH)) w_eff = FB'(sgm_pkg::MAX_WIDTH);
    h_eff = (height_r < FB'(3)) ? FB'(3) : height_r;
  end

  assign row_end   = {{(FB-CB){1'b0}}, col_r} >= (w_eff - FB'(1));
  assign frame_end = row_end && (row_r >= (h_eff - FB'(1)));

  assign in_full = s1_v_r & s1_int_r & q_full;
  assign accept  = in_push & ~in_full;
  assign s1_done = s1_v_r & ~(s1_int_r & q_full);
  assign q_push  = s1_v_r & s1_int_r & ~q_full;

  // raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + RB'(1);
      end else begin
        col_nxt = col_r + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_done) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pixel;
      s1_col_r  <= col_r;
      s1_int_r  <= (row_r >= RB'(2)) && (col_r >= CB'(2));
      s1_last_r <= frame_end;
    end
  end

  // two line stores packed as {upper, middle}
  sgm_ram #(.WIDTH(2*PB), .DEPTH(sgm_pkg::MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_col_r),
    .wdata ({mid, s1_pix_r}),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_data)
  );

  assign up  = rd_data[2*PB-1:PB];
  assign mid = rd_data[PB-1:0];

  // window: two older columns of top, middle, bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_done) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  // Sobel sums
  always_comb begin
    gx = - $signed({4'b0, win_r[0]}) + $signed({4'b0, up})
         - ($signed({4'b0, win_r[1]}) <<< 1) + ($signed({4'b0, mid}) <<< 1)
         - $signed({4'b0, win_r[2]}) + $signed({4'b0, s1_pix_r});
    gy = - $signed({4'b0, win_r[0]}) - ($signed({4'b0, win_r[3]}) <<< 1)
         - $signed({4'b0, up}) + $signed({4'b0, win_r[2]})
         + ($signed({4'b0, win_r[5]}) <<< 1) + $signed({4'b0, s1_pix_r});
    q_data.gx   = gx[sgm_pkg::GRAD_BITS-1:0];
    q_data.gy   = gy[sgm_pkg::GRAD_BITS-1:0];
    q_data.last = s1_last_r;
  end

endmodule
`default_nettype wire

// ===== rtl/sgm_queue.sv =====
`default_nettype none
module sgm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sgm_pkg::grad_t wdata,
  output      logic           full,
  input  wire logic           pop,
  output      logic           empty,
  output      sgm_pkg::grad_t rdata
);

  localparam int PW = sgm_pkg::Q_PTR_BITS;

  sgm_pkg::grad_t mem_r [sgm_pkg::Q_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == (PW+1)'(sgm_pkg::Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + PW'(1);
      if (do_pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sgm_back.sv =====
`default_nettype none
module sgm_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire sgm_pkg::grad_t                 q_data,
  output      logic                           q_pop,
  output      logic                           out_empty,
  input  wire logic                           out_pop,
  output      logic [sgm_pkg::MAG_BITS-1:0]   out_magnitude,
  output      logic [sgm_pkg::ANG_BITS-1:0]   out_angle,
  output      logic                           out_last_of_frame
);

  localparam int GB = sgm_pkg::GRAD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ITER = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r;
  logic signed [GB-1:0] gx_r, gy_r;
  logic last_r;
  logic [GB-2:0] ax_r, ay_r;
  logic signed [29:0] x_r, y_r, dx, dy;
  logic signed [21:0] z_r, zt;
  logic [21:0] rem_r, res_r, bit_r, trial;
  logic ov_r, fin_load;
  logic [21:0] zsel, a;
  logic [13:0] ar;
  logic [GB-1:0] ax_w, ay_w;

  assign out_empty = ~ov_r;
  assign q_pop     = (state_r == ST_IDLE) & ~q_empty;
  assign fin_load  = (state_r == ST_FIN) & (~ov_r | out_pop);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ITER;
      ST_ITER: if (cnt_r == 4'd15) state_nxt = ST_FIN;
      ST_FIN:  if (fin_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_load) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  assign ax_w = gx_r[GB-1] ? -gx_r : gx_r;
  assign ay_w = gy_r[GB-1] ? -gy_r : gy_r;

  // CORDIC shifts, truncating toward zero
  assign dx    = y_r[29] ? -((-y_r) >>> cnt_r) : (y_r >>> cnt_r);
  assign dy    = x_r >>> cnt_r;
  assign zt    = $signed({4'b0, sgm_pkg::ATAN_TAB[cnt_r]});
  assign trial = res_r + bit_r;

  // datapath: squares, CORDIC steps and root steps share the iteration count
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        gx_r   <= q_data.gx;
        gy_r   <= q_data.gy;
        last_r <= q_data.last;
      end
      ST_MUL: begin
        rem_r <= 22'(gx_r * gx_r) + 22'(gy_r * gy_r);
        res_r <= '0;
        bit_r <= 22'd1 << 20;
        ax_r  <= ax_w[GB-2:0];
        ay_r  <= ay_w[GB-2:0];
        x_r   <= $signed({3'b0, ax_w[GB-2:0], 16'b0});
        y_r   <= $signed({3'b0, ay_w[GB-2:0], 16'b0});
        z_r   <= '0;
        cnt_r <= '0;
      end
      ST_ITER: begin
        cnt_r <= cnt_r + 4'd1;
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + zt;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - zt;
        end
        if (bit_r != '0) begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      default: ;
    endcase
  end

  // angle: special cases, clamp, quadrant, round to 1/16 degree
  always_comb begin
    if (ay_r == '0) zsel = '0;
    else if (ax_r == '0) zsel = 22'(sgm_pkg::ANG_90);
    else if (z_r < 0) zsel = '0;
    else if (z_r > sgm_pkg::ANG_90) zsel = 22'(sgm_pkg::ANG_90);
    else zsel = 22'(z_r);
    case ({gx_r[GB-1], gy_r[GB-1]})
      2'b00:   a = zsel;
      2'b10:   a = sgm_pkg::ANG_180 - zsel;
      2'b11:   a = sgm_pkg::ANG_180 + zsel;
      default: a = sgm_pkg::ANG_360 - zsel;
    endcase
    ar = 14'((a + 22'd128) >> 8);
    if (ar >= sgm_pkg::ANG_FULL_OUT) ar = ar - sgm_pkg::ANG_FULL_OUT;
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_magnitude     <= sgm_pkg::MAG_BITS'(res_r + 22'(rem_r > res_r));
      out_angle         <= ar[sgm_pkg::ANG_BITS-1:0];
      out_last_of_frame <= last_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sobel_gradient_magnitude_angle.sv =====
// Sobel 3x3 gradient magnitude and direction over a raster pixel stream.
// Input channel: in_pixel with in_push/in_full; a pixel is taken on an edge
// with in_push high and in_full low. Result channel: out_magnitude,
// out_angle (1/16 degree, 0..5759) and out_last_of_frame, shown while
// out_empty is low and taken on an edge with out_pop high.
// Border pixels produce no result; every interior pixel produces one.
// Config: cfg_we/cfg_addr/cfg_wdata write frame_width (0) and frame_height
// (1); write only while the block is idle.
// Front end reads the line store and forms gx, gy at one pixel per cycle
// unless the queue is full; a four-entry queue feeds the back end, which
// runs a 16-step CORDIC and an 11-step square root in parallel and takes a
// new item only after its result is loaded, so the back end sets throughput.
// Border pixels pass the front end at one per cycle.
// Reset (synchronous, rst_n low) clears counters, window and queue, empties
// the result register and sets the frame to 640x480. The line store is not
// cleared. If the receiver stalls, the result is held, the queue fills and
// in_full rises.
`default_nettype none
module sobel_gradient_magnitude_angle (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_addr,
  input  wire logic [sgm_pkg::CFG_BITS-1:0]   cfg_wdata,
  input  wire logic                           in_push,
  input  wire logic [sgm_pkg::PIXEL_BITS-1:0] in_pixel,
  output      logic                           in_full,
  output      logic                           out_empty,
  input  wire logic                           out_pop,
  output      logic [sgm_pkg::MAG_BITS-1:0]   out_magnitude,
  output      logic [sgm_pkg::ANG_BITS-1:0]   out_angle,
  output      logic                           out_last_of_frame
);

  sgm_pkg::grad_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  sgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  sgm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  sgm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_magnitude     (out_magnitude),
    .out_angle         (out_angle),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
`default_nettype wire

// ===== rtl/sgm_checker.sv =====
`default_nettype none
module sgm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_empty,
  input wire logic                           out_pop,
  input wire logic [sgm_pkg::MAG_BITS-1:0]   out_magnitude,
  input wire logic [sgm_pkg::ANG_BITS-1:0]   out_angle,
  input wire logic                           out_last_of_frame
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // magnitude within the Sobel range
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_magnitude <= 11'd1443)
    else $error("magnitude out of range");

  // angle wrapped below a full turn
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_angle < 13'd5760)
    else $error("angle out of range");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_magnitude)
      && $stable(out_angle) && $stable(out_last_of_frame))
    else $error("stalled result changed");

endmodule

bind sobel_gradient_magnitude_angle sgm_checker u_sgm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_magnitude     (out_magnitude),
  .out_angle         (out_angle),
  .out_last_of_frame (out_last_of_frame)
);
`default_nettype wire

// ===== dv/tb_sobel_gradient_magnitude_angle.sv =====
`default_nettype none
module tb_sobel_gradient_magnitude_angle;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  typedef enum int {
    PAT_RANDOM, PAT_FLAT_LO, PAT_FLAT_HI, PAT_STEP_RIGHT, PAT_STEP_LEFT,
    PAT_STEP_DOWN, PAT_STEP_UP, PAT_DIAG, PAT_ANTIDIAG, PAT_EXTREME
  } pattern_t;

  typedef struct {
    logic [sgm_pkg::MAG_BITS-1:0] magnitude;
    logic [sgm_pkg::ANG_BITS-1:0] angle;
    logic                         last;
  } gradient_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_addr = '0;
  logic [sgm_pkg::CFG_BITS-1:0]   cfg_wdata = '0;
  logic                           in_push = 1'b0;
  logic [sgm_pkg::PIXEL_BITS-1:0] in_pixel = '0;
  logic                           in_full;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  logic [sgm_pkg::MAG_BITS-1:0]   out_magnitude;
  logic [sgm_pkg::ANG_BITS-1:0]   out_angle;
  logic                           out_last_of_frame;

  sobel_gradient_magnitude_angle dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [sgm_pkg::CFG_BITS-1:0] width_reg = sgm_pkg::WIDTH_RESET;
  logic [sgm_pkg::CFG_BITS-1:0] height_reg = sgm_pkg::HEIGHT_RESET;
  logic [7:0]            row_above [sgm_pkg::MAX_WIDTH];
  logic [7:0]            row_mid [sgm_pkg::MAX_WIDTH];
  logic [7:0]            window [6];
  int                    col_pos, row_pos;
  gradient_t             pending_grads [$];
  int                    errors = 0;
  int                    idle_cycles = 0;
  bit                    hold_req = 1'b0;
  bit                    no_gaps = 1'b0;
  int                    frame_w, frame_h;

  function automatic int rounded_sqrt(int n);
    int r;
    r = 0;
    for (int b = 15; b >= 0; b--)
      if ((r + (1 << b)) * (r + (1 << b)) <= n) r += (1 << b);
    if (n - r * r > r) r++;
    return r;
  endfunction

  function automatic int direction_16th(int gx, int gy);
    longint ax, ay, x, y, z, a, dx, dy;
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    if (ax == 0 && ay == 0) return 0;
    if (ay == 0) z = 0;
    else if (ax == 0) z = sgm_pkg::ANG_90;
    else begin
      x = ax * 65536;
      y = ay * 65536;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        // shifts truncate toward zero
        dx = (y < 0) ? -((-y) >>> i) : (y >>> i);
        dy = (x < 0) ? -((-x) >>> i) : (x >>> i);
        if (y > 0) begin
          x += dx; y -= dy; z += sgm_pkg::ATAN_TAB[i];
        end else begin
          x -= dx; y += dy; z -= sgm_pkg::ATAN_TAB[i];
        end
      end
      if (z < 0) z = 0;
      if (z > sgm_pkg::ANG_90) z = sgm_pkg::ANG_90;
    end
    if (gx >= 0 && gy >= 0) a = z;
    else if (gx < 0 && gy >= 0) a = longint'(sgm_pkg::ANG_180) - z;
    else if (gx < 0) a = longint'(sgm_pkg::ANG_180) + z;
    else a = longint'(sgm_pkg::ANG_360) - z;
    a = (a + 128) >>> 8;
    if (a >= sgm_pkg::ANG_FULL_OUT) a -= sgm_pkg::ANG_FULL_OUT;
    return int'(a);
  endfunction

  function automatic int eff_width(logic [sgm_pkg::CFG_BITS-1:0] v);
    return v < 3 ? 3 : (v > sgm_pkg::MAX_WIDTH ? sgm_pkg::MAX_WIDTH : int'(v));
  endfunction

  function automatic int eff_height(logic [sgm_pkg::CFG_BITS-1:0] v);
    return v < 3 ? 3 : int'(v);
  endfunction

  // advance the model by one accepted pixel
  task automatic predict_pixel(logic [7:0] p);
    int w, h, gx, gy;
    bit row_end, frame_end;
    logic [7:0] up, mid;
    gradient_t g;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    row_end = col_pos >= w - 1;
    frame_end = row_end && row_pos >= h - 1;
    up = row_above[col_pos];
    mid = row_mid[col_pos];
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = -window[0] + up - 2 * window[1] + 2 * mid - window[2] + p;
      gy = -window[0] - 2 * window[3] - up + window[2] + 2 * window[5] + p;
      g.magnitude = sgm_pkg::MAG_BITS'(rounded_sqrt(gx * gx + gy * gy));
      g.angle = sgm_pkg::ANG_BITS'(direction_16th(gx, gy));
      g.last = frame_end;
      pending_grads.push_back(g);
    end
    window[0] = window[3]; window[1] = window[4]; window[2] = window[5];
    window[3] = up; window[4] = mid; window[5] = p;
    row_above[col_pos] = mid;
    row_mid[col_pos] = p;
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : (row_pos + 1) & 12'hFFF;
    end else col_pos++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one pixel and wait until it is taken
  task automatic send_pixel(logic [7:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_pixel(p);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [sgm_pkg::CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == sgm_pkg::REG_FRAME_WIDTH) width_reg = val;
    else if (idx == sgm_pkg::REG_FRAME_HEIGHT) height_reg = val;
  endtask

  // frame size changes only at a frame boundary with the block idle
  task automatic set_frame(logic [sgm_pkg::CFG_BITS-1:0] w,
                           logic [sgm_pkg::CFG_BITS-1:0] h);
    wait_drained();
    write_reg(sgm_pkg::REG_FRAME_WIDTH, w);
    write_reg(sgm_pkg::REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
    frame_w = eff_width(w);
    frame_h = eff_height(h);
  endtask

  function automatic logic [7:0] pattern_pixel(pattern_t k, int r, int c);
    case (k)
      PAT_FLAT_LO:    return 8'd0;
      PAT_FLAT_HI:    return 8'd255;
      PAT_STEP_RIGHT: return c >= frame_w / 2 ? 8'd255 : 8'd0;
      PAT_STEP_LEFT:  return c >= frame_w / 2 ? 8'd0 : 8'd255;
      PAT_STEP_DOWN:  return r >= frame_h / 2 ? 8'd255 : 8'd0;
      PAT_STEP_UP:    return r >= frame_h / 2 ? 8'd0 : 8'd255;
      PAT_DIAG:       return c > r ? 8'd255 : 8'd0;
      PAT_ANTIDIAG:   return c + r > frame_w ? 8'd0 : 8'd255;
      PAT_EXTREME:    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:        return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(pattern_t k);
    for (int r = 0; r < frame_h; r++)
      for (int c = 0; c < frame_w; c++)
        send_pixel(pattern_pixel(k, r, c));
  endtask

  // flat fields, extreme pixels, steps in every direction
  task automatic test_directed_patterns();
    set_frame(12'd3, 12'd3);
    send_frame(PAT_FLAT_LO);
    send_frame(PAT_FLAT_HI);
    set_frame(12'd4, 12'd4);
    for (int k = PAT_STEP_RIGHT; k <= PAT_EXTREME; k++)
      send_frame(pattern_t'(k));
  endtask

  // register extremes, including values that saturate
  task automatic test_frame_size_extremes();
    set_frame(12'd0, 12'd2);
    send_frame(PAT_RANDOM);
    no_gaps = 1'b1;
    set_frame(12'd2, 12'd1);
    send_frame(PAT_EXTREME);
    no_gaps = 1'b0;
    set_frame(12'd1, 12'd0);
    send_frame(PAT_RANDOM);
  endtask

  // long receiver hold while input keeps coming, then a sender pause
  task automatic test_backpressure();
    set_frame(12'd20, 12'd10);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    for (int r = 0; r < frame_h; r++) begin
      if (r == 5) begin
        in_push <= 1'b0;
        while (pending_grads.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      for (int c = 0; c < frame_w; c++)
        send_pixel(8'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 1600) begin
      set_frame(12'($urandom_range(3, 24)), 12'($urandom_range(3, 12)));
      no_gaps = $urandom_range(0, 5) == 0;
      send_frame($urandom_range(0, 7) == 0 ? PAT_EXTREME : PAT_RANDOM);
      sent += frame_w * frame_h;
    end
    no_gaps = 1'b0;
  endtask

  // result side: random pop gaps, one long hold on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_pop <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // compare each popped item with the oldest prediction
  always @(posedge clk) begin
    gradient_t g;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_grads.size() == 0) begin
        $display("%0t: unexpected item mag=%0d ang=%0d last=%0d", $time,
                 out_magnitude, out_angle, out_last_of_frame);
        errors++;
      end else begin
        g = pending_grads.pop_front();
        if (out_magnitude !== g.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d", $time,
                   g.magnitude, out_magnitude);
          errors++;
        end
        if (out_angle !== g.angle) begin
          $display("%0t: angle expected %0d actual %0d", $time, g.angle, out_angle);
          errors++;
        end
        if (out_last_of_frame !== g.last) begin
          $display("%0t: last_of_frame expected %0d actual %0d", $time,
                   g.last, out_last_of_frame);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sobel_gradient_magnitude_angle test failed");
      $finish;
    end
  end

  initial begin
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < 6; i++) window[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_patterns();
    test_frame_size_extremes();
    test_backpressure();
    test_random_frames();
    wait_drained();
    if (errors == 0) $display("sobel_gradient_magnitude_angle test passed");
    else $display("sobel_gradient_magnitude_angle test failed");
    $finish;
  end

endmodule
`default_nettype wire
